/* rtl/lbb_pkg.sv */
package lbb_pkg;

  // Default sizes
  localparam int unsigned NumAnglesDef = 64;
  localparam int unsigned TableWDef    = 256;
  localparam int unsigned TableHDef    = 256;
  localparam int unsigned VoxelDimDef  = 1024;

  // Lookup table depth, fixed by the 16-bit load address
  localparam int unsigned TableDepth = 65536;
  localparam int unsigned TableAw    = 16;

  // APB address width: eight 32-bit registers
  localparam int unsigned CfgAw = 5;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TABLE = 2'd0,
    KIND_COEF  = 2'd1,
    KIND_VOXEL = 2'd2
  } kind_e;

  // Register indexes
  typedef enum logic [2:0] {
    REG_X_START_0     = 3'd0,
    REG_X_START_1     = 3'd1,
    REG_X_START_2     = 3'd2,
    REG_X_STEP_0      = 3'd3,
    REG_X_STEP_1      = 3'd4,
    REG_X_STEP_2      = 3'd5,
    REG_GRID_ORIGIN_0 = 3'd6,
    REG_GRID_ORIGIN_1 = 3'd7
  } reg_e;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [2:0][31:0] x_start;
    logic [2:0][31:0] x_step;
    logic [1:0][31:0] grid_origin;
  } cfg_t;

endpackage

/* rtl/lbb_regs.sv */
module lbb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbb_pkg::CfgAw-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lbb_pkg::cfg_t              cfg_o
);

  lbb_pkg::cfg_t cfg_q, cfg_d;
  lbb_pkg::reg_e idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lbb_pkg::reg_e'(paddr[lbb_pkg::CfgAw-1:2]);

  // Apply a register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        lbb_pkg::REG_X_START_0:     cfg_d.x_start[0]     = pwdata;
        lbb_pkg::REG_X_START_1:     cfg_d.x_start[1]     = pwdata;
        lbb_pkg::REG_X_START_2:     cfg_d.x_start[2]     = pwdata;
        lbb_pkg::REG_X_STEP_0:      cfg_d.x_step[0]      = pwdata;
        lbb_pkg::REG_X_STEP_1:      cfg_d.x_step[1]      = pwdata;
        lbb_pkg::REG_X_STEP_2:      cfg_d.x_step[2]      = pwdata;
        lbb_pkg::REG_GRID_ORIGIN_0: cfg_d.grid_origin[0] = pwdata;
        lbb_pkg::REG_GRID_ORIGIN_1: cfg_d.grid_origin[1] = pwdata;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_start     <= '0;
      cfg_q.x_step      <= {3{32'd65536}};
      cfg_q.grid_origin <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      lbb_pkg::REG_X_START_0:     prdata = cfg_q.x_start[0];
      lbb_pkg::REG_X_START_1:     prdata = cfg_q.x_start[1];
      lbb_pkg::REG_X_START_2:     prdata = cfg_q.x_start[2];
      lbb_pkg::REG_X_STEP_0:      prdata = cfg_q.x_step[0];
      lbb_pkg::REG_X_STEP_1:      prdata = cfg_q.x_step[1];
      lbb_pkg::REG_X_STEP_2:      prdata = cfg_q.x_step[2];
      lbb_pkg::REG_GRID_ORIGIN_0: prdata = cfg_q.grid_origin[0];
      lbb_pkg::REG_GRID_ORIGIN_1: prdata = cfg_q.grid_origin[1];
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/lut_backprojection_bilinear_top.sv */
// Voxel backprojection through a 2D lookup table with bilinear interpolation.
// Table and coefficient loads (kind 0 and 1) are taken when start is accepted and never
// raise busy. A voxel item (kind 2) raises busy and, when done, puts the
// saturated 48-bit sum on sum_value_o for one cycle under valid_o; the
// receiver cannot stall, so the result must be taken in that cycle. The
// position, projection and interpolation products share one 33x33 multiplier,
// and each memory has one read port: a voxel first forms its position, then
// for each angle projects, checks the bounds and, when the cell lies on the
// table, reads four neighbours and interpolates them. Voxels with an index
// at or beyond VOXEL_DIM and kind 3 give no result.
module lut_backprojection_bilinear_top #(
  parameter int unsigned NUM_ANGLES = lbb_pkg::NumAnglesDef,
  parameter int unsigned TABLE_W    = lbb_pkg::TableWDef,
  parameter int unsigned TABLE_H    = lbb_pkg::TableHDef,
  parameter int unsigned VOXEL_DIM  = lbb_pkg::VoxelDimDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbb_pkg::CfgAw-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind_i,
  input  logic [15:0]                load_address_i,
  input  logic signed [31:0]         load_value_i,
  input  logic [9:0]                 voxel_x_i,
  input  logic [9:0]                 voxel_y_i,
  input  logic [9:0]                 voxel_z_i,
  output logic                       valid_o,
  output logic signed [47:0]         sum_value_o
);

  localparam int unsigned CoefDepth = NUM_ANGLES * 6;
  localparam int unsigned CoefAw    = (CoefDepth > 1) ? $clog2(CoefDepth) : 1;
  localparam int unsigned AngW      = (NUM_ANGLES > 1) ? $clog2(NUM_ANGLES) : 1;
  localparam logic signed [26:0] IdxMax0 = 27'(TABLE_W - 2);
  localparam logic signed [26:0] IdxMax1 = 27'(TABLE_H - 2);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_POS    = 6'b000010,
    S_PROJ   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_TREAD  = 6'b010000,
    S_INTERP = 6'b100000
  } state_e;

  lbb_pkg::cfg_t cfg;

  lbb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer and datapath registers
  state_e                   state_q, state_d;
  logic [1:0]               ph_q, ph_d;
  logic [1:0]               c_q, c_d;
  logic                     r_q, r_d;
  logic [2:0]               k_q, k_d;
  logic [AngW-1:0]          ang_q, ang_d;
  logic [CoefAw-1:0]        base_q, base_d;
  logic [2:0][9:0]          vox_q, vox_d;
  logic [2:0][31:0]         pos_q, pos_d;
  logic signed [41:0]       acc_q, acc_d;
  logic signed [42:0]       u0_q, u0_d, u1_q, u1_d;
  logic [lbb_pkg::TableAw-1:0] tbase_q, tbase_d;
  logic [3:0][31:0]         nb_q, nb_d;
  logic signed [31:0]       top_q, top_d, bot_q, bot_d;
  logic signed [50:0]       iacc_q, iacc_d;
  logic signed [47:0]       sum_q, sum_d;
  logic                     valid_q, valid_d;
  logic signed [47:0]       res_q, res_d;
  logic signed [65:0]       prod_q;

  // Memories
  logic [31:0]              table_mem [lbb_pkg::TableDepth];
  logic [31:0]              coef_mem  [CoefDepth];
  logic [31:0]              tab_rd_q, coef_rd_q;
  logic [lbb_pkg::TableAw-1:0] tab_raddr;
  logic [CoefAw-1:0]        coef_raddr;

  logic                     accept;
  logic                     vox_ok;
  logic signed [32:0]       mul_a, mul_b;

  logic signed [43:0]       pos_sum;
  logic signed [41:0]       term;
  logic signed [41:0]       acc_new;
  logic signed [42:0]       u_new;
  logic signed [26:0]       idx0, idx1;
  logic                     on_table;
  logic [25:0]              row_off;
  logic [15:0]              f0, f1, fs;
  logic [16:0]              gs;
  logic signed [50:0]       isum;
  logic signed [31:0]       val;
  logic signed [48:0]       sum_ext;
  logic signed [47:0]       sum_sat;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign vox_ok = ({3'b0, voxel_x_i} < 13'(VOXEL_DIM)) &&
                  ({3'b0, voxel_y_i} < 13'(VOXEL_DIM)) &&
                  ({3'b0, voxel_z_i} < 13'(VOXEL_DIM));

  // Load writes
  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == lbb_pkg::KIND_TABLE)) begin
      table_mem[load_address_i] <= load_value_i;
    end
    tab_rd_q <= table_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == lbb_pkg::KIND_COEF) &&
        ({1'b0, load_address_i} < 17'(CoefDepth))) begin
      coef_mem[CoefAw'(load_address_i)] <= load_value_i;
    end
    coef_rd_q <= coef_mem[coef_raddr];
  end

  // Read addresses
  assign coef_raddr = base_q + CoefAw'(r_q) + CoefAw'({c_q, 1'b0});

  always_comb begin
    unique case (k_q[1:0])
      2'd0:    tab_raddr = tbase_q;
      2'd1:    tab_raddr = tbase_q + 16'd1;
      2'd2:    tab_raddr = tbase_q + 16'(TABLE_W);
      default: tab_raddr = tbase_q + 16'(TABLE_W + 1);
    endcase
  end

  // Fractions of the table coordinates
  assign f0 = u0_q[15:0];
  assign f1 = u1_q[15:0];
  assign fs = (k_q < 3'd4) ? f1 : f0;
  assign gs = 17'(17'd65536 - {1'b0, fs});

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_POS: begin
        mul_a = {cfg.x_step[c_q][31], cfg.x_step[c_q]};
        mul_b = {23'b0, vox_q[c_q]};
      end
      S_PROJ: begin
        mul_a = {coef_rd_q[31], coef_rd_q};
        mul_b = {pos_q[c_q][31], pos_q[c_q]};
      end
      S_INTERP: begin
        unique case (k_q)
          3'd0:    mul_a = {nb_q[0][31], nb_q[0]};
          3'd1:    mul_a = {nb_q[2][31], nb_q[2]};
          3'd2:    mul_a = {nb_q[1][31], nb_q[1]};
          3'd3:    mul_a = {nb_q[3][31], nb_q[3]};
          3'd4:    mul_a = {top_q[31], top_q};
          3'd5:    mul_a = {bot_q[31], bot_q};
          default: mul_a = '0;
        endcase
        mul_b = k_q[0] ? {17'b0, fs} : {16'b0, gs};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Arithmetic around the multiplier
  assign pos_sum  = 44'($signed(cfg.x_start[c_q])) + prod_q[43:0];
  assign term     = prod_q[65:24];
  assign acc_new  = ((c_q == 2'd0) ? 42'sd0 : acc_q) + term;
  assign u_new    = 43'(acc_new) - 43'($signed(cfg.grid_origin[r_q]));
  assign idx0     = u0_q[42:16];
  assign idx1     = u1_q[42:16];
  assign on_table = !idx0[26] && !idx1[26] && (idx0 <= IdxMax0) && (idx1 <= IdxMax1);
  assign row_off  = idx1[12:0] * 13'(TABLE_W);
  assign isum     = iacc_q + prod_q[50:0];
  assign val      = isum[47:16];
  assign sum_ext  = 49'(sum_q) + 49'(val);
  assign sum_sat  = (sum_ext[48] != sum_ext[47]) ?
                    {sum_ext[48], {47{~sum_ext[48]}}} : sum_ext[47:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    c_d     = c_q;
    r_d     = r_q;
    k_d     = k_q;
    ang_d   = ang_q;
    base_d  = base_q;
    vox_d   = vox_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    u0_d    = u0_q;
    u1_d    = u1_q;
    tbase_d = tbase_q;
    nb_d    = nb_q;
    top_d   = top_q;
    bot_d   = bot_q;
    iacc_d  = iacc_q;
    sum_d   = sum_q;
    valid_d = 1'b0;
    res_d   = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == lbb_pkg::KIND_VOXEL) && vox_ok) begin
          vox_d   = {voxel_z_i, voxel_y_i, voxel_x_i};
          c_d     = 2'd0;
          ph_d    = 2'd0;
          state_d = S_POS;
        end
      end

      // Form the voxel position, saturated to 32 bits
      S_POS: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (pos_sum[43:31] != {13{pos_sum[43]}}) begin
            pos_d[c_q] = {pos_sum[43], {31{~pos_sum[43]}}};
          end else begin
            pos_d[c_q] = pos_sum[31:0];
          end
          if (c_q == 2'd2) begin
            c_d     = 2'd0;
            r_d     = 1'b0;
            ang_d   = '0;
            base_d  = '0;
            sum_d   = '0;
            state_d = S_PROJ;
          end else begin
            c_d = c_q + 2'd1;
          end
        end
      end

      // Read coefficient, multiply, accumulate floored term
      S_PROJ: begin
        if (ph_q != 2'd2) begin
          ph_d = ph_q + 2'd1;
        end else begin
          ph_d  = 2'd0;
          acc_d = acc_new;
          if (c_q == 2'd2) begin
            c_d = 2'd0;
            if (r_q) begin
              u1_d    = u_new;
              state_d = S_CHECK;
            end else begin
              u0_d = u_new;
              r_d  = 1'b1;
            end
          end else begin
            c_d = c_q + 2'd1;
          end
        end
      end

      // Drop angles whose cell leaves the table
      S_CHECK: begin
        if (on_table) begin
          tbase_d = 16'(idx0[15:0] + row_off[15:0]);
          k_d     = 3'd0;
          state_d = S_TREAD;
        end else if (ang_q == AngW'(NUM_ANGLES - 1)) begin
          valid_d = 1'b1;
          res_d   = sum_q;
          state_d = S_IDLE;
        end else begin
          ang_d   = ang_q + AngW'(1);
          base_d  = base_q + CoefAw'(6);
          r_d     = 1'b0;
          c_d     = 2'd0;
          ph_d    = 2'd0;
          state_d = S_PROJ;
        end
      end

      // Fetch the four neighbours
      S_TREAD: begin
        if (k_q != 3'd0) begin
          nb_d[k_q[1:0] - 2'd1] = tab_rd_q;
        end
        if (k_q == 3'd4) begin
          k_d     = 3'd0;
          ph_d    = 2'd0;
          state_d = S_INTERP;
        end else begin
          k_d = k_q + 3'd1;
        end
      end

      // Bilinear weights: blend the two rows in each column, then across
      S_INTERP: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (!k_q[0]) begin
            iacc_d = prod_q[50:0];
            k_d    = k_q + 3'd1;
          end else if (k_q == 3'd1) begin
            top_d = val;
            k_d   = k_q + 3'd1;
          end else if (k_q == 3'd3) begin
            bot_d = val;
            k_d   = k_q + 3'd1;
          end else begin
            if (ang_q == AngW'(NUM_ANGLES - 1)) begin
              valid_d = 1'b1;
              res_d   = sum_sat;
              state_d = S_IDLE;
            end else begin
              sum_d   = sum_sat;
              ang_d   = ang_q + AngW'(1);
              base_d  = base_q + CoefAw'(6);
              r_d     = 1'b0;
              c_d     = 2'd0;
              state_d = S_PROJ;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= '0;
      c_q     <= '0;
      r_q     <= 1'b0;
      k_q     <= '0;
      ang_q   <= '0;
      base_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      c_q     <= c_d;
      r_q     <= r_d;
      k_q     <= k_d;
      ang_q   <= ang_d;
      base_q  <= base_d;
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    vox_q   <= vox_d;
    pos_q   <= pos_d;
    acc_q   <= acc_d;
    u0_q    <= u0_d;
    u1_q    <= u1_d;
    tbase_q <= tbase_d;
    nb_q    <= nb_d;
    top_q   <= top_d;
    bot_q   <= bot_d;
    iacc_q  <= iacc_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
  end

  assign valid_o     = valid_q;
  assign sum_value_o = res_q;

`ifndef SYNTHESIS
  // A result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe held");

  // A result arrives only once the voxel work is done
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result while busy");

  // An accepted voxel raises busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == lbb_pkg::KIND_VOXEL) && vox_ok) |=> busy)
    else $error("voxel not started");

  // Loads never raise busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i != lbb_pkg::KIND_VOXEL)) |=> !busy)
    else $error("load raised busy");
`endif

endmodule
